[rtl/bst_pkg.sv]
// shared types, token codes and keyword table for the source tokenizer
package bst_pkg;

    localparam int MAX_NUMBER_CHARS  = 63;
    localparam int MAX_NAME_CHARS    = 127;
    localparam int MAX_STRING_CHARS  = 511;
    localparam int KEYWORD_MAX_CHARS = 9;
    localparam int POSITION_BITS     = 16;
    localparam int KW_COUNT          = 71;
    localparam int COUNT_BITS        = 9;
    localparam int KW_BITS           = 8 * KEYWORD_MAX_CHARS;

    localparam logic [4:0] K_EOF    = 5'd0;
    localparam logic [4:0] K_NL     = 5'd1;
    localparam logic [4:0] K_NUM    = 5'd2;
    localparam logic [4:0] K_STR    = 5'd3;
    localparam logic [4:0] K_ID     = 5'd4;
    localparam logic [4:0] K_KW     = 5'd5;
    localparam logic [4:0] K_PLUS   = 5'd6;
    localparam logic [4:0] K_MINUS  = 5'd7;
    localparam logic [4:0] K_STAR   = 5'd8;
    localparam logic [4:0] K_SLASH  = 5'd9;
    localparam logic [4:0] K_CARET  = 5'd10;
    localparam logic [4:0] K_EQ     = 5'd11;
    localparam logic [4:0] K_LE     = 5'd12;
    localparam logic [4:0] K_NE     = 5'd13;
    localparam logic [4:0] K_LT     = 5'd14;
    localparam logic [4:0] K_GE     = 5'd15;
    localparam logic [4:0] K_GT     = 5'd16;
    localparam logic [4:0] K_LPAR   = 5'd17;
    localparam logic [4:0] K_RPAR   = 5'd18;
    localparam logic [4:0] K_COMMA  = 5'd19;
    localparam logic [4:0] K_SEMI   = 5'd20;
    localparam logic [4:0] K_COLON  = 5'd21;
    localparam logic [4:0] K_HASH   = 5'd22;
    localparam logic [4:0] K_ATSIGN = 5'd23;
    localparam logic [4:0] K_DOT    = 5'd24;
    localparam logic [4:0] K_QUEST  = 5'd25;
    localparam logic [4:0] K_DOLLAR = 5'd26;
    localparam logic [4:0] K_PCT    = 5'd27;

    typedef struct packed {
        logic [4:0]                 kind;
        logic [6:0]                 kw;
        logic [POSITION_BITS-1:0]   line;
        logic [POSITION_BITS-1:0]   col;
        logic [COUNT_BITS-1:0]      len;
        logic                       last;
    } tok_t;

    typedef struct packed {
        logic [1:0] cnt;
        tok_t       t0;
        tok_t       t1;
    } push_t;

    typedef struct packed {
        logic       hit;
        logic [6:0] idx;
    } kw_hit_t;

    localparam logic [KW_BITS-1:0] KW_TABLE [KW_COUNT] = '{
        "PRINT", "USING", "INPUT", "LET", "IF", "THEN", "ELSE", "ON", "GOTO", "GOSUB",
        "RETURN", "PROCEDURE", "CLASS", "NEW", "FOR", "TO", "STEP", "NEXT", "DIM", "DATA",
        "READ", "RESTORE", "OPEN", "CLOSE", "WRITE", "GET", "PUT", "LINE", "AS", "OUTPUT",
        "APPEND", "POKE", "SAVE", "DELETE", "MERGE", "ERROR", "RESUME", "SLEEP", "BEEP",
        "CLS", "DEF", "DEFINT", "DEFSNG", "DEFDBL", "DEFSTR", "TRON", "TROFF", "STOP",
        "CONT", "SOUND", "TAB", "WHILE", "WEND", "DO", "LOOP", "UNTIL", "EXIT", "CLEAR",
        "AT", "END", "ENDIF", "REM", "CASE", "OF", "WHEN", "OTHERWISE", "ENDCASE", "AND",
        "OR", "NOT", "MOD"
    };

    // name is held right-aligned and zero-padded, like the table literals
    function automatic kw_hit_t kw_lookup(input logic [KW_BITS-1:0] name,
                                          input logic [COUNT_BITS-1:0] cnt);
        kw_hit_t r;
        r = '0;
        if (cnt != '0 && cnt <= COUNT_BITS'(KEYWORD_MAX_CHARS))
        begin
            for (int i = KW_COUNT - 1; i >= 0; i--)
            begin
                if (KW_TABLE[i] == name)
                begin
                    r.hit = 1'b1;
                    r.idx = 7'(i);
                end
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] b);
        logic [4:0] k;
        case (b)
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            "^":     k = K_CARET;
            "=":     k = K_EQ;
            "(":     k = K_LPAR;
            ")":     k = K_RPAR;
            ",":     k = K_COMMA;
            ";":     k = K_SEMI;
            ":":     k = K_COLON;
            "#":     k = K_HASH;
            "@":     k = K_ATSIGN;
            ".":     k = K_DOT;
            "?":     k = K_QUEST;
            "$":     k = K_DOLLAR;
            "%":     k = K_PCT;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        return (b >= "a" && b <= "z") ? b - 8'd32 : b;
    endfunction

endpackage

[rtl/bst_byte_if.sv]
// byte channel carrying source text beats
interface bst_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

[rtl/bst_token_if.sv]
// token channel carrying result beats
interface bst_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [6:0]  keyword_index;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [8:0]  text_length;
    logic        last_of_run;

    modport source (output valid, output token_kind, output keyword_index,
                    output start_line, output start_column, output text_length,
                    output last_of_run, input ready);
    modport sink (input valid, input token_kind, input keyword_index,
                  input start_line, input start_column, input text_length,
                  input last_of_run, output ready);
endinterface

[rtl/bst_scanner.sv]
// front end: classifies each byte and forms up to two tokens per beat
module bst_scanner
    import bst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bst_byte_if.sink   text_in,
    input  logic       space,
    output push_t      push
);

    typedef enum logic [3:0] {
        M_IDLE, M_CR, M_LT, M_GT, M_INT, M_FRAC, M_ESTART, M_EXP, M_STR, M_NAME, M_REM
    } mode_t;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [COUNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [KW_BITS-1:0]       kw_reg, kw_next;

    logic                     fire;
    kw_hit_t                  kwh;
    tok_t                     toks [2];
    logic [1:0]               ntok;
    logic                     redo;
    logic [7:0]               b;
    logic [4:0]               pk;

    assign fire          = text_in.valid && text_in.ready;
    assign text_in.ready = space;
    assign kwh           = kw_lookup(kw_reg, cnt_reg);
    assign b             = text_in.text_byte;
    assign pk            = punct_kind(b);

    function automatic tok_t mk(input logic [4:0] k, input logic [6:0] kw,
                                input logic [POSITION_BITS-1:0] ln,
                                input logic [POSITION_BITS-1:0] cl,
                                input logic [COUNT_BITS-1:0] len);
        tok_t t;
        t.kind = k;
        t.kw   = kw;
        t.line = ln;
        t.col  = cl;
        t.len  = len;
        t.last = 1'b0;
        return t;
    endfunction

    // pending token of a mode; kind K_EOF marks none
    function automatic tok_t pend(input mode_t m, input logic [POSITION_BITS-1:0] ln,
                                  input logic [POSITION_BITS-1:0] st,
                                  input logic [COUNT_BITS-1:0] c, input kw_hit_t h);
        tok_t t;
        case (m)
            M_LT:                           t = mk(K_LT, '0, ln, st, '0);
            M_GT:                           t = mk(K_GT, '0, ln, st, '0);
            M_INT, M_FRAC, M_ESTART, M_EXP: t = mk(K_NUM, '0, ln, st, c);
            M_STR:                          t = mk(K_STR, '0, ln, st, c);
            M_NAME:                         t = h.hit ? mk(K_KW, h.idx, ln, st, c)
                                                      : mk(K_ID, '0, ln, st, c);
            default:                        t = mk(K_EOF, '0, ln, st, '0);
        endcase
        return t;
    endfunction

    always_comb
    begin
        tok_t pt;
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        start_next = start_reg;
        cnt_next   = cnt_reg;
        kw_next    = kw_reg;
        toks[0]    = '0;
        toks[1]    = '0;
        ntok       = '0;
        redo       = 1'b0;
        pt         = pend(mode_reg, line_reg, start_reg, cnt_reg, kwh);
        if (text_in.end_of_text)
        begin
            if (pt.kind != K_EOF)
            begin
                toks[0] = pt;
                ntok    = 2'd1;
            end
            toks[ntok[0]] = mk(K_EOF, '0, line_reg, col_reg, '0);
            ntok          = ntok + 2'd1;
            mode_next     = M_IDLE;
            line_next     = POSITION_BITS'(1);
            col_next      = POSITION_BITS'(1);
            start_next    = POSITION_BITS'(1);
            cnt_next      = '0;
        end
        else
        begin
            case (mode_reg)
                M_IDLE:
                    redo = 1'b1;
                M_CR:
                begin
                    mode_next = M_IDLE;
                    redo      = b != 8'h0A;
                end
                M_LT, M_GT:
                begin
                    mode_next = M_IDLE;
                    if (b == "=" || (mode_reg == M_LT && b == ">"))
                    begin
                        toks[0] = mk(b == ">" ? K_NE : (mode_reg == M_LT ? K_LE : K_GE),
                                     '0, line_reg, start_reg, '0);
                        ntok    = 2'd1;
                        if (col_reg != POS_MAX)
                            col_next = col_reg + 1'b1;
                    end
                    else
                    begin
                        toks[0] = pt;
                        ntok    = 2'd1;
                        redo    = 1'b1;
                    end
                end
                M_INT, M_FRAC, M_ESTART, M_EXP:
                begin
                    if (mode_reg == M_ESTART && (b == "+" || b == "-"))
                    begin
                        cnt_next  = cnt_reg + 1'b1;
                        mode_next = M_EXP;
                    end
                    else if (is_digit(b) && cnt_reg < COUNT_BITS'(MAX_NUMBER_CHARS))
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        if (mode_reg == M_ESTART)
                            mode_next = M_EXP;
                    end
                    else if (mode_reg == M_INT && b == ".")
                    begin
                        cnt_next  = cnt_reg + 1'b1;
                        mode_next = M_FRAC;
                    end
                    else if ((mode_reg == M_INT || mode_reg == M_FRAC) && (b == "e" || b == "E")
                             && cnt_reg < COUNT_BITS'(MAX_NUMBER_CHARS - 3))
                    begin
                        cnt_next  = cnt_reg + 1'b1;
                        mode_next = M_ESTART;
                    end
                    else
                    begin
                        toks[0]   = pt;
                        ntok      = 2'd1;
                        mode_next = M_IDLE;
                        redo      = 1'b1;
                    end
                    if (mode_next != M_IDLE && col_reg != POS_MAX)
                        col_next = col_reg + 1'b1;
                end
                M_STR:
                begin
                    if (b == "\"")
                    begin
                        toks[0]   = pt;
                        ntok      = 2'd1;
                        mode_next = M_IDLE;
                        if (col_reg != POS_MAX)
                            col_next = col_reg + 1'b1;
                    end
                    else if (b == 8'h0A || cnt_reg >= COUNT_BITS'(MAX_STRING_CHARS))
                    begin
                        toks[0]   = pt;
                        ntok      = 2'd1;
                        mode_next = M_IDLE;
                        redo      = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        if (col_reg != POS_MAX)
                            col_next = col_reg + 1'b1;
                    end
                end
                M_NAME:
                begin
                    if ((is_digit(b) || is_alpha(b) || b == "_" || b == "$" || b == "%"
                         || b == "!" || b == "#") && cnt_reg < COUNT_BITS'(MAX_NAME_CHARS))
                    begin
                        if (cnt_reg < COUNT_BITS'(KEYWORD_MAX_CHARS))
                            kw_next = {kw_reg[KW_BITS-9:0], to_upper(b)};
                        cnt_next = cnt_reg + 1'b1;
                        if (col_reg != POS_MAX)
                            col_next = col_reg + 1'b1;
                    end
                    else
                    begin
                        toks[0]   = pt;
                        ntok      = 2'd1;
                        mode_next = M_IDLE;
                        redo      = 1'b1;
                    end
                end
                M_REM:
                begin
                    if (b == 8'h0A || b == 8'h0D)
                    begin
                        mode_next = M_IDLE;
                        redo      = 1'b1;
                    end
                    else if (col_reg != POS_MAX)
                        col_next = col_reg + 1'b1;
                end
                default:
                begin
                    mode_next = M_IDLE;
                    redo      = 1'b1;
                end
            endcase
            if (redo)
            begin
                if (b == 8'h0A || b == 8'h0D)
                begin
                    toks[ntok[0]] = mk(K_NL, '0, line_reg, col_next, '0);
                    ntok          = ntok + 2'd1;
                    if (line_reg != POS_MAX)
                        line_next = line_reg + 1'b1;
                    col_next  = POSITION_BITS'(1);
                    mode_next = (b == 8'h0D) ? M_CR : M_IDLE;
                end
                else
                begin
                    if (b == "\"" || b == "<" || b == ">")
                    begin
                        mode_next  = (b == "\"") ? M_STR : ((b == "<") ? M_LT : M_GT);
                        start_next = col_next;
                        cnt_next   = '0;
                    end
                    else if (b == "'")
                        mode_next = M_REM;
                    else if (pk != K_EOF)
                    begin
                        toks[ntok[0]] = mk(pk, '0, line_reg, col_next, '0);
                        ntok          = ntok + 2'd1;
                    end
                    else if (is_digit(b) || is_alpha(b) || b == "_")
                    begin
                        mode_next  = is_digit(b) ? M_INT : M_NAME;
                        start_next = col_next;
                        cnt_next   = COUNT_BITS'(1);
                        kw_next    = {{(KW_BITS-8){1'b0}}, to_upper(b)};
                    end
                    if (col_next != POS_MAX)
                        col_next = col_next + 1'b1;
                end
            end
        end
        if (ntok == 2'd1)
            toks[0].last = 1'b1;
        if (ntok == 2'd2)
            toks[1].last = 1'b1;
        push.cnt = fire ? ntok : 2'd0;
        push.t0  = toks[0];
        push.t1  = toks[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            line_reg  <= POSITION_BITS'(1);
            col_reg   <= POSITION_BITS'(1);
            start_reg <= POSITION_BITS'(1);
            cnt_reg   <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            start_reg <= start_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            kw_reg <= kw_next;
    end

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n) line_reg != '0)
        else $error("line counter reached zero");
    a_col_nonzero: assert property (@(posedge clk) disable iff (!rst_n) col_reg != '0)
        else $error("column counter reached zero");
    a_eot_resets: assert property (@(posedge clk) disable iff (!rst_n)
        fire && text_in.end_of_text |=> mode_reg == M_IDLE && cnt_reg == '0)
        else $error("end marker did not return scanner to idle");

endmodule

[rtl/bst_token_queue.sv]
// back end: four-entry token queue; one beat out per ready cycle
module bst_token_queue
    import bst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  push_t       push,
    output logic        space,
    bst_token_if.source token_out
);

    tok_t       mem [4];
    logic [1:0] wp_reg, wp_next;
    logic [1:0] rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    tok_t       head;

    assign space = cnt_reg <= 3'd2;
    assign pop   = token_out.valid && token_out.ready;
    assign head  = mem[rp_reg];

    assign token_out.valid         = cnt_reg != '0;
    assign token_out.token_kind    = head.kind;
    assign token_out.keyword_index = head.kw;
    assign token_out.start_line    = head.line;
    assign token_out.start_column  = head.col;
    assign token_out.text_length   = head.len;
    assign token_out.last_of_run   = head.last;

    always_comb
    begin
        wp_next  = wp_reg + push.cnt;
        rp_next  = rp_reg + {1'b0, pop};
        cnt_next = cnt_reg + {1'b0, push.cnt} - {2'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem[wp_reg] <= push.t0;
        if (push.cnt == 2'd2)
            mem[wp_reg + 2'd1] <= push.t1;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'd4)
        else $error("token queue overflow");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> cnt_reg <= 3'd2)
        else $error("push without room");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg == rp_reg + cnt_reg[1:0])
        else $error("queue pointers disagree with fill count");

endmodule

[rtl/basic_source_tokenizer_unit.sv]
// top level of the source tokenizer: scanner front end and token queue back end
//
//   channel    dir   beat
//   text_in    in    one source byte or the end marker
//   token_out  out   one token: kind, keyword index, line, column, length, last
//
// one byte per cycle; a byte yielding two tokens is taken at full rate while
// the four-entry token queue has room for two, so sustained rate is set by the
// single-beat output drain. rst_n clears the scanner to line 1 column 1 and
// empties the queue. a stalled token_out fills the queue and then holds text_in.
module basic_source_tokenizer_unit
    import bst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bst_byte_if.sink    text_in,
    bst_token_if.source token_out
);

    push_t push;
    logic  space;

    bst_scanner u_scanner (
        .clk     (clk),
        .rst_n   (rst_n),
        .text_in (text_in),
        .space   (space),
        .push    (push)
    );

    bst_token_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (space),
        .token_out (token_out)
    );

endmodule
